// ===== sv/psi_pkg.sv =====
// Package: types and constants shared by the projection sample interpolator.
`default_nettype none
package psi_pkg;

    typedef logic signed [31:0] q16_t;
    typedef logic        [9:0]  sidx_t;
    typedef logic        [0:0]  cfg_idx_t;
    typedef logic        [0:0]  opcode_t;

    localparam opcode_t  OP_WRITE        = 1'b0;
    localparam opcode_t  OP_QUERY        = 1'b1;

    localparam cfg_idx_t CFG_INTERP_MODE = 1'b0;
    localparam cfg_idx_t CFG_INV_SPACING = 1'b1;

    localparam logic     MODE_LINEAR     = 1'b0;
    localparam logic     MODE_NEAREST    = 1'b1;

    localparam q16_t         INV_SPACING_RESET = 32'sd65536;
    localparam logic [16:0]  ONE_Q16           = 17'd65536;
    localparam logic [15:0]  HALF_Q16          = 16'd32768;
    localparam q16_t         Q16_MAX           = 32'sh7FFF_FFFF;
    localparam q16_t         Q16_MIN           = 32'sh8000_0000;

endpackage
`default_nettype wire

// ===== sv/psi_if.sv =====
// Interfaces: request, result and configuration channels of the interpolator.
`default_nettype none
interface psi_req_if;
    logic               valid;
    logic               ready;
    psi_pkg::opcode_t   opcode;
    psi_pkg::sidx_t     sample_index;
    psi_pkg::q16_t      sample_value;
    psi_pkg::q16_t      t_position;

    modport source (output valid, opcode, sample_index, sample_value, t_position,
                    input ready);
    modport sink   (input valid, opcode, sample_index, sample_value, t_position,
                    output ready);
endinterface

interface psi_rsp_if;
    logic               valid;
    logic               ready;
    psi_pkg::q16_t      interp_value;
    logic               saturated;

    modport source (output valid, interp_value, saturated, input ready);
    modport sink   (input valid, interp_value, saturated, output ready);
endinterface

interface psi_cfg_if;
    logic               valid;
    logic               ready;
    psi_pkg::cfg_idx_t  index;
    logic [31:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/projection_sample_interpolator.sv =====
// Top level: pipelined linear / nearest-neighbour projection sample interpolator.
//
//  channel  dir  fields                                              transfer when
//  req      in   opcode, sample_index, sample_value, t_position      valid && ready
//  rsp      out  interp_value, saturated                             valid && ready
//  cfg      in   index (0 interp_mode, 1 inv_spacing), data          valid && ready
//
//  One item per cycle sustained while rsp.ready is high; a query passes every stage register before rsp.valid rises.
//  Stages: t*inv_spacing multiplier, sample store read (two ports), weight multipliers,
//  sum / floor / saturate into the output register. Writes give no result.
//  Reset clears valid bits and configuration; the sample store is not cleared.
//  Each stage advances whenever the one after it has room, so req.ready drops only when
//  all stages are full and the output waits. cfg.ready is always high.
`default_nettype none
module projection_sample_interpolator #(
    parameter int HALF_SPAN = 511
) (
    input  wire          clk,
    input  wire          rst_n,
    psi_req_if.sink      req,
    psi_rsp_if.source    rsp,
    psi_cfg_if.sink      cfg
);
    import psi_pkg::*;

    localparam int DEPTH = 2 * HALF_SPAN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [32:0] H_S   = 33'(HALF_SPAN);
    localparam logic        [31:0] DEPTH_U = 32'(DEPTH);

    // configuration
    logic mode_reg;
    q16_t inv_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LINEAR;
            inv_reg  <= INV_SPACING_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_INTERP_MODE: mode_reg <= cfg.data[0];
                CFG_INV_SPACING: inv_reg  <= cfg.data;
                default:         ;
            endcase
        end
    end

    // stage enables
    logic en1, en2, en3, en4;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;

    assign en4 = !out_valid_reg || rsp.ready;
    assign en3 = !s3_valid_reg  || en4;
    assign en2 = !s2_valid_reg  || en3;
    assign en1 = !s1_valid_reg  || en2;
    assign req.ready = en1;

    // stage 1: position times reciprocal spacing
    opcode_t                s1_op_reg;
    sidx_t                  s1_idx_reg;
    q16_t                   s1_val_reg;
    logic signed [63:0]     s1_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && req.valid)
        begin
            s1_op_reg   <= req.opcode;
            s1_idx_reg  <= req.sample_index;
            s1_val_reg  <= req.sample_value;
            s1_prod_reg <= req.t_position * inv_reg;
        end
    end

    // stage 2: offsets, range flags, store access
    logic signed [47:0]     u;
    logic signed [31:0]     m1;
    logic signed [32:0]     m1_x;
    logic signed [32:0]     a0_full;
    logic [AW-1:0]          a0, a1;
    logic                   in0, in1, wr_ok;

    assign u       = s1_prod_reg[63:16];
    assign m1      = u[47:16];
    assign m1_x    = 33'(m1);
    assign a0_full = H_S - m1_x;
    assign a0      = a0_full[AW-1:0];
    assign a1      = a0 - AW'(1);
    assign in0     = (m1_x >= -H_S) && (m1_x <= H_S);
    assign in1     = (m1_x >= -H_S - 33'sd1) && (m1_x <= H_S - 33'sd1);
    assign wr_ok   = {22'd0, s1_idx_reg} < DEPTH_U;

    logic [31:0]            mem [DEPTH];
    q16_t                   rd0_reg, rd1_reg;
    logic [15:0]            s2_f_reg;
    logic                   s2_in0_reg, s2_in1_reg;

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            if (s1_op_reg == OP_WRITE)
            begin
                if (wr_ok)
                    mem[AW'(s1_idx_reg)] <= s1_val_reg;
            end
            else
            begin
                rd0_reg    <= mem[a0];
                rd1_reg    <= mem[a1];
                s2_f_reg   <= u[15:0];
                s2_in0_reg <= in0;
                s2_in1_reg <= in1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg && (s1_op_reg == OP_QUERY);
    end

    // stage 3: tent weights / nearest pick
    q16_t                   term0, term1;
    logic [16:0]            w0;
    logic signed [49:0]     s3_p0_reg, s3_p1_reg;
    q16_t                   s3_near_reg;

    assign term0 = s2_in0_reg ? rd0_reg : '0;
    assign term1 = s2_in1_reg ? rd1_reg : '0;
    assign w0    = ONE_Q16 - {1'b0, s2_f_reg};

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_p0_reg   <= term0 * $signed({1'b0, w0});
            s3_p1_reg   <= term1 * $signed({2'b00, s2_f_reg});
            s3_near_reg <= (s2_f_reg <= HALF_Q16) ? term0 : term1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en3)
            s3_valid_reg <= s2_valid_reg;
    end

    // stage 4: sum, floor, saturate in linear mode; nearest pick passed through otherwise
    logic signed [50:0]     acc;
    logic signed [34:0]     res;
    q16_t                   value_next;
    logic                   sat_next;
    q16_t                   out_value_reg;
    logic                   out_sat_reg;

    assign acc = 51'(s3_p0_reg) + 51'(s3_p1_reg);
    assign res = acc[50:16];

    always_comb
    begin
        value_next = s3_near_reg;
        sat_next   = 1'b0;
        if (mode_reg == MODE_LINEAR)
        begin
            if (res > 35'(Q16_MAX))
            begin
                value_next = Q16_MAX;
                sat_next   = 1'b1;
            end
            else if (res < 35'(Q16_MIN))
            begin
                value_next = Q16_MIN;
                sat_next   = 1'b1;
            end
            else
                value_next = res[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && s3_valid_reg)
        begin
            out_value_reg <= value_next;
            out_sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en4)
            out_valid_reg <= s3_valid_reg;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.interp_value = out_value_reg;
    assign rsp.saturated    = out_sat_reg;

endmodule
`default_nettype wire

// ===== sv/psi_checker.sv =====
// Checker: port-level properties of the interpolator, bound to the top level.
`default_nettype none
module psi_checker (
    input wire          clk,
    input wire          rst_n,
    input wire          req_ready,
    input wire          rsp_valid,
    input wire          rsp_ready,
    input wire [31:0]   rsp_value,
    input wire          rsp_sat,
    input wire          cfg_ready
);
    import psi_pkg::*;

    // a waiting result holds until its transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_sat))
        else $error("result changed while stalled");

    // a clipped result sits at one of the rails
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_sat |-> rsp_value == Q16_MAX || rsp_value == Q16_MIN)
        else $error("saturated flag without rail value");

    // with the output register empty the pipeline always has room
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind projection_sample_interpolator psi_checker u_psi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_value (rsp.interp_value),
    .rsp_sat   (rsp.saturated),
    .cfg_ready (cfg.ready)
);
`default_nettype wire

// ===== tb/tb_projection_sample_interpolator.sv =====
// Testbench: self-checking stimulus and prediction for the projection sample interpolator.
module tb_projection_sample_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import psi_pkg::*;

    localparam int HALF_SPAN   = 511;
    localparam int DEPTH       = 2 * HALF_SPAN + 1;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        q16_t value;
        logic saturated;
    } interp_result_t;

    logic clk = 1'b0;
    logic rst_n;

    psi_req_if req_bus ();
    psi_rsp_if rsp_bus ();
    psi_cfg_if cfg_bus ();

    projection_sample_interpolator #(.HALF_SPAN(HALF_SPAN)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // predictor state
    q16_t           column [DEPTH];
    bit             written [DEPTH];
    logic           kernel_mode = MODE_LINEAR;
    q16_t           spacing_recip = INV_SPACING_RESET;
    interp_result_t expected_values [$];

    int  errors = 0;
    int  cycle_count = 0;
    bit  stalls_on = 1'b1;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // floor(t * recip / 2^16): integer detector offset above bit 16, fraction in low 16 bits
    function automatic longint scaled_position(q16_t pos);
        return (longint'(pos) * longint'(spacing_recip)) >>> 16;
    endfunction

    function automatic longint sample_at(longint offset);
        if (offset < -HALF_SPAN || offset > HALF_SPAN)
            return 0;
        return longint'(column[HALF_SPAN - offset]);
    endfunction

    function automatic interp_result_t interpolate(q16_t pos);
        longint         u;
        longint         m1;
        longint         frac;
        longint         acc;
        longint         res;
        interp_result_t r;
        u    = scaled_position(pos);
        m1   = u >>> 16;
        frac = u & 64'hFFFF;
        if (kernel_mode == MODE_LINEAR)
        begin
            acc = sample_at(m1) * (longint'(ONE_Q16) - frac) + sample_at(m1 + 1) * frac;
            res = acc >>> 16;
        end
        else
        begin
            res = (frac <= longint'(HALF_Q16)) ? sample_at(m1) : sample_at(m1 + 1);
        end
        r.saturated = 1'b0;
        if (res > longint'(Q16_MAX))
        begin
            res = longint'(Q16_MAX);
            r.saturated = 1'b1;
        end
        else if (res < longint'(Q16_MIN))
        begin
            res = longint'(Q16_MIN);
            r.saturated = 1'b1;
        end
        r.value = q16_t'(res);
        return r;
    endfunction

    // result side: ready stalls in bursts, checked at the rising edge
    initial
    begin
        int burst;
        burst = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
                burst--;
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                burst = $urandom_range(1, 14) - 1;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                burst = $urandom_range(0, 19);
            end
        end
    end

    always @(posedge clk)
    begin
        interp_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_values.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got value %h saturated %b",
                         $time, rsp_bus.interp_value, rsp_bus.saturated);
            end
            else
            begin
                want = expected_values.pop_front();
                if (rsp_bus.interp_value !== want.value)
                begin
                    errors++;
                    $display("%0t: interp_value expected %h got %h",
                             $time, want.value, rsp_bus.interp_value);
                end
                if (rsp_bus.saturated !== want.saturated)
                begin
                    errors++;
                    $display("%0t: saturated expected %b got %b",
                             $time, want.saturated, rsp_bus.saturated);
                end
            end
        end
    end

    // entered and left at a falling edge; valid stays high into the next item unless a gap follows
    task automatic send_item(opcode_t op, sidx_t idx, q16_t value, q16_t pos);
        int gap;
        if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.opcode       <= op;
        req_bus.sample_index <= idx;
        req_bus.sample_value <= value;
        req_bus.t_position   <= pos;
        do @(posedge clk); while (!req_bus.ready);
        if (op == OP_WRITE)
        begin
            if (int'(idx) < DEPTH)
            begin
                column[idx]  = value;
                written[idx] = 1'b1;
            end
        end
        else
        begin
            expected_values.push_back(interpolate(pos));
        end
        @(negedge clk);
    endtask

    // both neighbours are read whatever the kernel, so load any that were never written
    task automatic send_query(q16_t pos);
        longint m1;
        longint offset;
        m1 = scaled_position(pos) >>> 16;
        for (offset = m1; offset <= m1 + 1; offset++)
        begin
            if (offset >= -HALF_SPAN && offset <= HALF_SPAN && !written[HALF_SPAN - offset])
                send_item(OP_WRITE, sidx_t'(HALF_SPAN - offset), q16_t'($urandom),
                          q16_t'($urandom));
        end
        send_item(OP_QUERY, sidx_t'($urandom), q16_t'($urandom), pos);
    endtask

    task automatic settle_pipeline();
        req_bus.valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(logic mode, q16_t recip);
        settle_pipeline();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_INTERP_MODE;
        cfg_bus.data  <= {31'b0, mode};
        do @(posedge clk); while (!cfg_bus.ready);
        kernel_mode = mode;
        @(negedge clk);
        cfg_bus.index <= CFG_INV_SPACING;
        cfg_bus.data  <= recip;
        do @(posedge clk); while (!cfg_bus.ready);
        spacing_recip = recip;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // positions spread over the column and a little past each end, some anywhere at all
    function automatic q16_t pick_position();
        longint      span;
        int unsigned r;
        if (spacing_recip == 0 || $urandom_range(0, 7) == 0)
            return q16_t'($urandom);
        span = ((longint'(HALF_SPAN) + 3) <<< 32) /
               (spacing_recip < 0 ? -longint'(spacing_recip) : longint'(spacing_recip));
        if (span > longint'(Q16_MAX))
            span = longint'(Q16_MAX);
        r = $urandom_range(32'(2 * span), 0);
        return q16_t'(longint'(r) - span);
    endfunction

    task automatic run_mix(int count);
        int   roll;
        q16_t value;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       value = Q16_MAX;
                1:       value = Q16_MIN;
                2:       value = '0;
                default: value = q16_t'($urandom);
            endcase
            if (roll < 25)
                send_item(OP_WRITE, sidx_t'($urandom_range(0, DEPTH - 1)), value,
                          q16_t'($urandom));
            else if (roll < 28)
                send_item(OP_WRITE, sidx_t'(DEPTH), value, q16_t'($urandom));
            else
                send_query(pick_position());
        end
    endtask

    task automatic test_linear_directed();
        set_config(MODE_LINEAR, INV_SPACING_RESET);
        send_item(OP_WRITE, 10'd0,    Q16_MAX,        '0);
        send_item(OP_WRITE, 10'd1,    Q16_MAX,        '0);
        send_item(OP_WRITE, 10'd1022, Q16_MIN,        '0);
        send_item(OP_WRITE, 10'd1021, Q16_MIN,        '0);
        send_item(OP_WRITE, 10'd511,  32'sh0003_0000, '0);
        send_item(OP_WRITE, 10'd510,  -32'sh0005_0000, '0);
        // index past the column: dropped
        send_item(OP_WRITE, 10'd1023, 32'sh1234_5678, '0);
        send_query(32'sh0000_0000);
        send_query(32'sh0000_8000);
        send_query(32'sh01FE_0001);
        send_query(32'sh01FF_8000);  // upper neighbour off the column
        send_query(32'sh0200_0000);  // both off the column
        send_query(32'shFE00_C000);  // lower neighbour off the column
        send_query(32'shFE01_0000);
        send_query(32'shFE02_4000);
        send_query(Q16_MAX);
        send_query(Q16_MIN);
    endtask

    task automatic test_nearest_directed();
        set_config(MODE_NEAREST, INV_SPACING_RESET);
        send_query(32'sh0000_8000);  // exact half rounds down
        send_query(32'sh0000_8001);
        send_query(32'sh0000_7FFF);
        send_query(32'sh01FF_8001);
        send_query(32'shFE00_8001);
        send_query(32'shFFFF_FFFF);
    endtask

    task automatic test_spacing_extremes();
        set_config(MODE_LINEAR, Q16_MIN);
        run_mix(16);
        set_config(MODE_NEAREST, Q16_MAX);
        run_mix(16);
        set_config(MODE_LINEAR, '0);
        run_mix(12);
        set_config(MODE_NEAREST, '0);
        run_mix(8);
    endtask

    task automatic test_random_mix();
        set_config(MODE_LINEAR, INV_SPACING_RESET);
        run_mix(20);
        set_config(MODE_NEAREST, INV_SPACING_RESET);
        run_mix(20);
        set_config(MODE_LINEAR, 32'sh0002_0000);
        run_mix(16);
        set_config(MODE_NEAREST, -32'sh0000_8000);
        run_mix(16);
        stalls_on = 1'b0;
        set_config(MODE_LINEAR, -32'sh0001_0000);
        run_mix(12);
        stalls_on = 1'b1;
        set_config(MODE_NEAREST, q16_t'($urandom));
        run_mix(12);
        set_config(MODE_LINEAR, q16_t'($urandom));
        run_mix(12);
    endtask

    task automatic test_full_rate();
        stalls_on = 1'b0;
        set_config(MODE_LINEAR, 32'sh0000_C000);
        run_mix(20);
        set_config(MODE_NEAREST, INV_SPACING_RESET);
        run_mix(20);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.opcode       = OP_WRITE;
        req_bus.sample_index = '0;
        req_bus.sample_value = '0;
        req_bus.t_position   = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_INTERP_MODE;
        cfg_bus.data         = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_linear_directed();
        test_nearest_directed();
        test_spacing_extremes();
        test_random_mix();
        test_full_rate();

        settle_pipeline();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
